[rtl/core/slws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slws_pkg: shared types and constants
// Operation codes, register map, state machine type and the stage record.
// ----------------------------------------------------------------------------
package slws_pkg;

    localparam int NUM_STAGES_DEF = 48;
    localparam logic [31:0] SCALE_RESET = 32'd1000000;
    localparam logic [9:0] TICK_MUL = 10'd1000;

    typedef enum logic [1:0] {
        OP_TICKS = 2'd0,
        OP_US    = 2'd1,
        OP_DRAIN = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [1:0] REG_SCALE  = 2'd0;
    localparam logic [1:0] REG_ENABLE = 2'd1;
    localparam logic [1:0] REG_MASK   = 2'd2;

    localparam logic KIND_STAGE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_RD,
        ST_WR,
        ST_DRD,
        ST_DCHK,
        ST_DOUT,
        ST_SUM,
        ST_FIN
    } t_state;

    // One stage entry as it lies in memory.
    typedef struct packed {
        logic [63:0] cnt;
        logic [63:0] tot;
        logic [63:0] mx;
        logic [63:0] rec;
        logic [63:0] mev;
        logic [63:0] msrc;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

[rtl/core/slws_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slws_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module slws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write or registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[rtl/core/stage_latency_window_stats.sv]
`timescale 1ns / 1ps
// A microsecond record is read, updated and written back; a tick record first
// passes the 1000x multiply and 64 restoring divide steps (no divide when the
// scale is zero), then the read and the write. A drain, taken only while
// enabled, reads and checks each of NUM_STAGES stages, spends one more step
// per non-empty stage and then flushes the last record and the summary, held
// up by output stalls. One request is worked at a time. Reset clears the memory
// by a pass over all NUM_STAGES entries during which no request is accepted.
// ----------------------------------------------------------------------------
// stage_latency_window_stats: windowed per-stage latency statistics
// Stage statistics live in one RAM; records read, modify and write back.
// ----------------------------------------------------------------------------
module stage_latency_window_stats
    import slws_pkg::*;
#(
    parameter int NUM_STAGES = NUM_STAGES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: operation[1:0], stage[7:2], elapsed[71:8], source_id[135:72]
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: stage_index[5:0], sample_count, window sum, max_us, recent_us,
    // max event number, max_source (each 64 bits from bit 6 up), zero filled
    output logic [391:0] m_tdata,
    // tuser: kind
    output logic         m_tuser,
    output logic         m_tlast
);
    localparam int AW = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int CW = $clog2(NUM_STAGES + 1);
    localparam logic [CW-1:0] LAST_S = CW'(NUM_STAGES - 1);

    t_state r_state, n_state;
    logic [31:0] r_scale;
    logic        r_en;
    logic [63:0] r_mask;
    logic [63:0] r_seq;
    logic [CW-1:0] r_idx;
    logic        r_clr;
    logic [5:0]  r_st;
    logic [63:0] r_us, r_src;
    logic [63:0] r_prod;
    logic [63:0] r_rem;
    logic [6:0]  r_bit;
    logic        r_hw;
    logic [5:0]  r_wst;
    logic [63:0] r_wmx, r_wev, r_wsrc;
    logic        r_pend;
    t_entry      r_pent;
    logic [5:0]  r_pst;
    logic        r_ov;
    logic [391:0] r_od;
    logic        r_ok, r_ol;

    // APB registers.
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_en    <= 1'b0;
            r_mask  <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                REG_SCALE:  r_scale <= pwdata[31:0];
                REG_ENABLE: r_en    <= pwdata[0];
                REG_MASK:   r_mask  <= pwdata;
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr[4:3])
            REG_SCALE:  prdata = {32'd0, r_scale};
            REG_ENABLE: prdata = {63'd0, r_en};
            REG_MASK:   prdata = r_mask;
            default:    prdata = '0;
        endcase
    end

    // Memory port.
    logic         mem_we;
    logic [AW-1:0] mem_addr;
    t_entry       mem_wd, mem_rd;
    slws_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_STAGES)) u_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(mem_wd), .o_rdata(mem_rd)
    );

    logic [1:0]  in_op;
    logic [5:0]  in_st;
    assign in_op = s_tdata[1:0];
    assign in_st = s_tdata[7:2];
    assign s_tready = (r_state == ST_IDLE) && !r_clr;
    logic acc;
    assign acc = s_tvalid && s_tready;
    logic out_free;
    assign out_free = !r_ov || m_tready;

    // Divider step and modified entry.
    logic [64:0] d_try;
    logic [63:0] d_rem;
    assign d_rem = {r_rem[62:0], r_prod[63]};
    assign d_try = {1'b0, d_rem} - {33'd0, r_scale};
    t_entry upd;
    logic [63:0] seq1;
    assign seq1 = r_seq + 64'd1;
    always_comb begin
        upd = mem_rd;
        upd.cnt = mem_rd.cnt + 64'd1;
        upd.tot = mem_rd.tot + r_us;
        upd.rec = r_us;
        if (r_us > mem_rd.mx) upd.mx = r_us;
        if (r_us >= mem_rd.mx) begin
            upd.mev = seq1;
            upd.msrc = r_src;
        end
    end
    logic elig;
    assign elig = !r_mask[6'(r_idx)] && (!r_hw || mem_rd.mx > r_wmx);

    // A result is loaded into the output register in this cycle.
    logic ov_load;
    assign ov_load = out_free &&
        (((r_state == ST_DOUT || r_state == ST_SUM) && r_pend) ||
         (r_state == ST_FIN && r_hw));

    // Held record: the entry pending emission and its stage.
    typedef struct packed {
        t_entry     e;
        logic [5:0] s;
    } t_held;
    t_held r_pent_q;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DOUT && out_free) begin
            r_pent_q <= '{e: r_pent, s: r_pst};
        end
    end

    function automatic logic [391:0] pack(input t_held h);
        pack = {2'b00, h.e.msrc, h.e.mev, h.e.rec, h.e.mx, h.e.tot, h.e.cnt, h.s};
    endfunction

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (acc) begin
                if (in_op == OP_DRAIN && r_en) n_state = ST_DRD;
                else if (in_st < 6'(NUM_STAGES) && in_op == OP_TICKS)
                    n_state = ST_MUL;
                else if (in_st < 6'(NUM_STAGES) && in_op == OP_US)
                    n_state = ST_RD;
            end
            ST_MUL:  n_state = (r_scale == 32'd0) ? ST_RD : ST_DIV;
            ST_DIV:  if (r_bit == 7'd63) n_state = ST_RD;
            ST_RD:   n_state = ST_WR;
            ST_WR:   n_state = ST_IDLE;
            ST_DRD:  n_state = ST_DCHK;
            ST_DCHK: if (mem_rd.cnt != 64'd0) n_state = ST_DOUT;
                     else if (r_idx == LAST_S) n_state = ST_SUM;
                     else n_state = ST_DRD;
            ST_DOUT: if (out_free) n_state = (r_idx == LAST_S) ? ST_SUM : ST_DRD;
            ST_SUM:  if (out_free) n_state = ST_FIN;
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory control.
    always_comb begin
        mem_we = 1'b0;
        mem_addr = r_idx[AW-1:0];
        mem_wd = '0;
        if (r_clr) begin
            mem_we = 1'b1;
        end else if (r_state == ST_RD) begin
            mem_addr = r_st[AW-1:0];
        end else if (r_state == ST_WR) begin
            mem_addr = r_st[AW-1:0];
            mem_we = 1'b1;
            mem_wd = upd;
        end else if (r_state == ST_DCHK) begin
            mem_we = 1'b1;
            mem_wd.rec = mem_rd.rec;
        end
    end

    // Datapath and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_clr   <= 1'b1;
            r_idx   <= '0;
            r_seq   <= '0;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
            r_hw    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= ov_load || (r_ov && !m_tready);
            if (r_clr) begin
                if (r_idx == LAST_S) begin
                    r_clr <= 1'b0;
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            unique case (r_state)
                ST_IDLE: if (acc) begin
                    r_st   <= in_st;
                    r_us   <= s_tdata[71:8];
                    r_src  <= s_tdata[135:72];
                    r_idx  <= '0;
                    r_hw   <= 1'b0;
                    r_pend <= 1'b0;
                end
                ST_MUL: begin
                    r_prod <= 64'(r_us * TICK_MUL);
                    r_rem  <= '0;
                    r_bit  <= '0;
                    r_us   <= '0;
                end
                ST_DIV: begin
                    r_prod <= {r_prod[62:0], 1'b0};
                    r_bit  <= r_bit + 7'd1;
                    if (!d_try[64]) begin
                        r_rem <= d_try[63:0];
                        r_us  <= {r_us[62:0], 1'b1};
                    end else begin
                        r_rem <= d_rem;
                        r_us  <= {r_us[62:0], 1'b0};
                    end
                end
                ST_WR: r_seq <= seq1;
                ST_DCHK: begin
                    if (mem_rd.cnt != 64'd0) begin
                        r_pent <= mem_rd;
                        r_pst  <= 6'(r_idx);
                        if (elig) begin
                            r_hw   <= 1'b1;
                            r_wst  <= 6'(r_idx);
                            r_wmx  <= mem_rd.mx;
                            r_wev  <= mem_rd.mev;
                            r_wsrc <= mem_rd.msrc;
                        end
                    end else if (r_idx != LAST_S) begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ST_DOUT: if (out_free) begin
                    // Emit the previous held record, keep this one pending.
                    if (r_pend) begin
                        r_od <= pack(r_pent_q);
                        r_ok <= KIND_STAGE;
                        r_ol <= 1'b0;
                    end
                    r_pend <= 1'b1;
                    if (r_idx != LAST_S) r_idx <= r_idx + CW'(1);
                end
                ST_SUM: if (out_free) begin
                    if (r_pend) begin
                        r_od <= pack(r_pent_q);
                        r_ok <= KIND_STAGE;
                        r_ol <= !r_hw;
                    end
                end
                ST_FIN: if (out_free) begin
                    if (r_hw) begin
                        r_od <= {2'b00, r_wsrc, r_wev, 64'd0, r_wmx, 64'd0, 64'd0,
                                 r_wst};
                        r_ok <= KIND_SUMMARY;
                        r_ol <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = r_od;
    assign m_tuser  = r_ok;
    assign m_tlast  = r_ol;

    // No item is taken during the clearing pass.
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !s_tready) else $error("item accepted while clearing");
    // A valid output holds while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_tready) |=> r_ov) else $error("output dropped");
    // The divider finishes within 64 steps.
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_bit < 7'd64)) else $error("divider overrun");
endmodule
